// ===== rtl/core/pdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_pkg
// Types and constants shared by the pair drag force pipeline.
// ----------------------------------------------------------------------------
package pdf_pkg;

   localparam int DATA_W  = 32;              // Q16.16 word
   localparam int LANES   = 3;               // x, y, z
   localparam int DIVR_W  = 62;              // squared distance inside the cutoff
   localparam int DVND_W  = 96;              // |d.dv| * |d_i|
   localparam int QUOT_W  = 34;              // quotient bits produced by the divider
   localparam int P_W     = QUOT_W + 2;      // signed, rounded normal component
   localparam int T_W     = P_W + 1;         // signed tangential component
   localparam int A_W     = DATA_W + P_W;    // normal gain product
   localparam int B_W     = DATA_W + T_W;    // tangential gain product
   localparam int SUM_W   = B_W + 1;         // force before rounding
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_GAIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TANGENTIAL_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_DISTANCE = 2'd2;

   // Handshake state travelling with each item. Before the cutoff test, hit
   // carries the pair-selected flag.
   typedef struct packed {
      logic valid;
      logic hit;
   } ctl_type;

endpackage
`default_nettype wire

// ===== rtl/core/pair_drag_force_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pair_drag_force_unit
// Normal and tangential drag force on the first atom of a particle pair.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_     in         pair position and velocity differences, selected flag
//  rsp_     out        force vector, interacting and saturated flags
//  csr_     in         gain and cutoff register writes
//
// One transaction is accepted per cycle while no result waits on rsp_tready; each
// passes through the front stages, the 34-stage quotient pipeline and the force stages.
// Reset clears all valid bits and the gain and cutoff registers to zero.
// The whole pipeline holds while a result waits on rsp_tready.
// ----------------------------------------------------------------------------
module pair_drag_force_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [191:0]                   req_tdata,  // delta_x, delta_y, delta_z,
                                                           // delta_vx, delta_vy, delta_vz
   input  wire logic                           req_tuser,  // pair_selected
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [95:0]                         rsp_tdata,  // force_x, force_y, force_z
   output logic [1:0]                          rsp_tuser,  // interacting, saturated
   input  wire logic                           csr_wen,
   input  wire logic [pdf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_wdata
);

   localparam int L = pdf_pkg::LANES;
   localparam int W = pdf_pkg::DATA_W;

   logic [W-1:0]  normal_gain_ff;
   logic [W-1:0]  tangential_gain_ff;
   logic [30:0]   cutoff_ff;

   logic          advance;

   pdf_pkg::ctl_type               front_ctl, div_ctl;
   logic [pdf_pkg::DIVR_W-1:0]     front_div;
   logic [L-1:0][pdf_pkg::DVND_W-1:0] front_dvnd;
   logic [L-1:0]                   front_neg;
   logic [L-1:0][W-1:0]            front_dv, div_dv, force_w;
   logic [L-1:0][pdf_pkg::P_W-1:0] div_p;
   logic                           inter_w, sat_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_gain_ff     <= '0;
         tangential_gain_ff <= '0;
         cutoff_ff          <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            pdf_pkg::CSR_NORMAL_GAIN:     normal_gain_ff     <= csr_wdata;
            pdf_pkg::CSR_TANGENTIAL_GAIN: tangential_gain_ff <= csr_wdata;
            pdf_pkg::CSR_CUTOFF_DISTANCE: cutoff_ff          <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Every stage moves together; the output register is the last stage.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   pdf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .in_valid     (req_tvalid),
      .in_sel       (req_tuser),
      .in_d         (req_tdata[95:0]),
      .in_dv        (req_tdata[191:96]),
      .cutoff       (cutoff_ff),
      .out_ctl      (front_ctl),
      .out_divisor  (front_div),
      .out_dividend (front_dvnd),
      .out_neg      (front_neg),
      .out_dv       (front_dv)
   );

   pdf_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .in_ctl      (front_ctl),
      .in_divisor  (front_div),
      .in_dividend (front_dvnd),
      .in_neg      (front_neg),
      .in_dv       (front_dv),
      .out_ctl     (div_ctl),
      .out_p       (div_p),
      .out_dv      (div_dv)
   );

   pdf_force #(
      .FRAC_BITS (FRAC_BITS)
   ) u_force (
      .clock           (clock),
      .reset           (reset),
      .enable          (advance),
      .in_ctl          (div_ctl),
      .in_p            (div_p),
      .in_dv           (div_dv),
      .normal_gain     (normal_gain_ff),
      .tangential_gain (tangential_gain_ff),
      .out_valid       (rsp_tvalid),
      .out_force       (force_w),
      .out_interacting (inter_w),
      .out_saturated   (sat_w)
   );

   assign rsp_tdata = force_w;
   assign rsp_tuser = {sat_w, inter_w};

`ifndef NO_ASSERTIONS
   a_sat_needs_inter : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("saturated set on a pair that does not interact");

   a_idle_pair_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("non-zero force on a pair that does not interact");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/pdf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_front
// Squares, dot product, cutoff test and the wide dividend for each lane.
// ----------------------------------------------------------------------------
module pdf_front (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          enable,
   input  wire logic                                          in_valid,
   input  wire logic                                          in_sel,
   input  wire logic [pdf_pkg::LANES-1:0][pdf_pkg::DATA_W-1:0] in_d,
   input  wire logic [pdf_pkg::LANES-1:0][pdf_pkg::DATA_W-1:0] in_dv,
   input  wire logic [30:0]                                   cutoff,
   output pdf_pkg::ctl_type                                   out_ctl,
   output logic [pdf_pkg::DIVR_W-1:0]                         out_divisor,
   output logic [pdf_pkg::LANES-1:0][pdf_pkg::DVND_W-1:0]     out_dividend,
   output logic [pdf_pkg::LANES-1:0]                          out_neg,
   output logic [pdf_pkg::LANES-1:0][pdf_pkg::DATA_W-1:0]     out_dv
);

   localparam int L = pdf_pkg::LANES;
   localparam int W = pdf_pkg::DATA_W;

   pdf_pkg::ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff, ctl6_ff;

   logic [L-1:0][W-1:0]  d1_ff, dv1_ff, d2_ff, dv2_ff, d3_ff, dv3_ff;
   logic [L-1:0][W-1:0]  dv4_ff, dv5_ff, dv6_ff;
   logic [L-1:0][63:0]   sq2_ff, dp2_ff;
   logic [61:0]          cut2_ff;
   logic [63:0]          rsq3_ff;
   logic signed [65:0]   dot3_ff;
   logic [63:0]          mag_dot4_ff;
   logic [L-1:0][W-1:0]  mag_d4_ff;
   logic [L-1:0]         neg4_ff, neg5_ff, neg6_ff;
   logic [61:0]          div4_ff, div5_ff, div6_ff;
   logic [L-1:0][63:0]   pp_lo5_ff, pp_hi5_ff;
   logic [L-1:0][95:0]   dvnd6_ff;

   logic [63:0]          rsq_in;
   logic signed [65:0]   dot_in;
   logic                 hit_in;

   always_comb begin
      rsq_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      dot_in = 66'($signed(dp2_ff[0])) + 66'($signed(dp2_ff[1]))
             + 66'($signed(dp2_ff[2]));
      hit_in = ctl2_ff.hit && (rsq_in != 64'd0) && (rsq_in < {2'b00, cut2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else if (enable) begin
         ctl1_ff <= '{valid: in_valid, hit: in_sel};
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= '{valid: ctl2_ff.valid, hit: hit_in};
         ctl4_ff <= ctl3_ff;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= ctl5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d1_ff   <= in_d;
         dv1_ff  <= in_dv;
         cut2_ff <= {31'd0, cutoff} * {31'd0, cutoff};
         d2_ff   <= d1_ff;
         dv2_ff  <= dv1_ff;
         rsq3_ff <= rsq_in;
         dot3_ff <= dot_in;
         d3_ff   <= d2_ff;
         dv3_ff  <= dv2_ff;
         mag_dot4_ff <= dot3_ff[65] ? 64'(-dot3_ff) : 64'(dot3_ff);
         div4_ff <= rsq3_ff[61:0];
         dv4_ff  <= dv3_ff;
         div5_ff <= div4_ff;
         dv5_ff  <= dv4_ff;
         neg5_ff <= neg4_ff;
         div6_ff <= div5_ff;
         dv6_ff  <= dv5_ff;
         neg6_ff <= neg5_ff;
         for (int i = 0; i < L; i++) begin
            sq2_ff[i] <= 64'($signed(d1_ff[i])) * 64'($signed(d1_ff[i]));
            dp2_ff[i] <= 64'($signed(d1_ff[i])) * 64'($signed(dv1_ff[i]));
            mag_d4_ff[i] <= d3_ff[i][W-1] ? (~d3_ff[i] + 32'd1) : d3_ff[i];
            neg4_ff[i] <= dot3_ff[65] ^ d3_ff[i][W-1];
            // The 64 by 32 bit product is split into two 32 by 32 halves.
            pp_lo5_ff[i] <= {32'd0, mag_dot4_ff[31:0]} * {32'd0, mag_d4_ff[i]};
            pp_hi5_ff[i] <= {32'd0, mag_dot4_ff[63:32]} * {32'd0, mag_d4_ff[i]};
            dvnd6_ff[i]  <= {32'd0, pp_lo5_ff[i]} + {pp_hi5_ff[i], 32'd0};
         end
      end
   end

   assign out_ctl      = ctl6_ff;
   assign out_divisor  = div6_ff;
   assign out_dividend = dvnd6_ff;
   assign out_neg      = neg6_ff;
   assign out_dv       = dv6_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pdf_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_divider
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor, followed by rounding and sign restore.
// ----------------------------------------------------------------------------
module pdf_divider (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          enable,
   input  pdf_pkg::ctl_type                                   in_ctl,
   input  wire logic [pdf_pkg::DIVR_W-1:0]                    in_divisor,
   input  wire logic [pdf_pkg::LANES-1:0][pdf_pkg::DVND_W-1:0] in_dividend,
   input  wire logic [pdf_pkg::LANES-1:0]                     in_neg,
   input  wire logic [pdf_pkg::LANES-1:0][pdf_pkg::DATA_W-1:0] in_dv,
   output pdf_pkg::ctl_type                                   out_ctl,
   output logic [pdf_pkg::LANES-1:0][pdf_pkg::P_W-1:0]        out_p,
   output logic [pdf_pkg::LANES-1:0][pdf_pkg::DATA_W-1:0]     out_dv
);

   localparam int L  = pdf_pkg::LANES;
   localparam int W  = pdf_pkg::DATA_W;
   localparam int Q  = pdf_pkg::QUOT_W;
   localparam int R  = pdf_pkg::DIVR_W;
   localparam int N  = pdf_pkg::DVND_W;

   // Entry 0 captures the operands; entry k holds the state after k bits.
   pdf_pkg::ctl_type      ctl_ff [Q+1];
   logic [R-1:0]          divisor_ff [Q+1];
   logic [L-1:0][R-1:0]   rem_ff [Q+1];
   logic [L-1:0][Q-1:0]   low_ff [Q+1];
   logic [L-1:0]          neg_ff [Q+1];
   logic [L-1:0][W-1:0]   dv_ff [Q+1];

   pdf_pkg::ctl_type      ctl_r1_ff, ctl_r2_ff;
   logic [L-1:0][Q:0]     qr_r1_ff;
   logic [L-1:0]          neg_r1_ff;
   logic [L-1:0][W-1:0]   dv_r1_ff, dv_r2_ff;
   logic [L-1:0][Q+1:0]   p_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (enable) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   // The quotient is known to stay below 2^Q, so the upper dividend bits
   // already form a remainder below the divisor.
   always_ff @(posedge clock) begin
      if (enable) begin
         divisor_ff[0] <= in_divisor;
         neg_ff[0]     <= in_neg;
         dv_ff[0]      <= in_dv;
         for (int j = 0; j < L; j++) begin
            rem_ff[0][j] <= in_dividend[j][N-1:Q];
            low_ff[0][j] <= in_dividend[j][Q-1:0];
         end
      end
   end

   for (genvar k = 1; k <= Q; k++) begin : g_stage
      logic [L-1:0][R:0]   trial;
      logic [L-1:0]        ge;
      logic [L-1:0][R-1:0] rem_in;

      always_comb begin
         for (int j = 0; j < L; j++) begin
            trial[j]  = {rem_ff[k-1][j], low_ff[k-1][j][Q-1]};
            ge[j]     = trial[j] >= {1'b0, divisor_ff[k-1]};
            rem_in[j] = ge[j] ? R'(trial[j] - {1'b0, divisor_ff[k-1]}) : trial[j][R-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (enable) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            divisor_ff[k] <= divisor_ff[k-1];
            neg_ff[k]     <= neg_ff[k-1];
            dv_ff[k]      <= dv_ff[k-1];
            for (int j = 0; j < L; j++) begin
               rem_ff[k][j] <= rem_in[j];
               low_ff[k][j] <= {low_ff[k-1][j][Q-2:0], ge[j]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_r1_ff <= '0;
         ctl_r2_ff <= '0;
      end else if (enable) begin
         ctl_r1_ff <= ctl_ff[Q];
         ctl_r2_ff <= ctl_r1_ff;
      end
   end

   // Round to nearest with ties away from zero, then restore the sign.
   always_ff @(posedge clock) begin
      if (enable) begin
         neg_r1_ff <= neg_ff[Q];
         dv_r1_ff  <= dv_ff[Q];
         dv_r2_ff  <= dv_r1_ff;
         for (int j = 0; j < L; j++) begin
            qr_r1_ff[j] <= {1'b0, low_ff[Q][j]}
                         + (Q+1)'({rem_ff[Q][j], 1'b0} >= {1'b0, divisor_ff[Q]});
            p_r2_ff[j]  <= neg_r1_ff[j] ? -{1'b0, qr_r1_ff[j]} : {1'b0, qr_r1_ff[j]};
         end
      end
   end

   assign out_ctl = ctl_r2_ff;
   assign out_p   = p_r2_ff;
   assign out_dv  = dv_r2_ff;

`ifndef NO_ASSERTIONS
   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      ctl_ff[Q].valid && ctl_ff[Q].hit |->
         (rem_ff[Q][0] < divisor_ff[Q]) && (rem_ff[Q][1] < divisor_ff[Q])
         && (rem_ff[Q][2] < divisor_ff[Q]))
      else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/pdf_force.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdf_force
// Tangential split, gain products, rounding and saturation of the force.
// ----------------------------------------------------------------------------
module pdf_force #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          enable,
   input  pdf_pkg::ctl_type                                   in_ctl,
   input  wire logic [pdf_pkg::LANES-1:0][pdf_pkg::P_W-1:0]    in_p,
   input  wire logic [pdf_pkg::LANES-1:0][pdf_pkg::DATA_W-1:0] in_dv,
   input  wire logic [pdf_pkg::DATA_W-1:0]                    normal_gain,
   input  wire logic [pdf_pkg::DATA_W-1:0]                    tangential_gain,
   output logic                                               out_valid,
   output logic [pdf_pkg::LANES-1:0][pdf_pkg::DATA_W-1:0]     out_force,
   output logic                                               out_interacting,
   output logic                                               out_saturated
);

   localparam int L  = pdf_pkg::LANES;
   localparam int W  = pdf_pkg::DATA_W;
   localparam int PW = pdf_pkg::P_W;
   localparam int TW = pdf_pkg::T_W;
   localparam int AW = pdf_pkg::A_W;
   localparam int BW = pdf_pkg::B_W;
   localparam int SW = pdf_pkg::SUM_W;
   localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

   pdf_pkg::ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   logic             valid4_ff, inter4_ff, sat4_ff;

   logic [L-1:0][PW-1:0] p1_ff;
   logic [L-1:0][TW-1:0] t1_ff;
   logic signed [AW-1:0] a2_ff [L];
   logic signed [BW-1:0] b2_ff [L];
   logic signed [SW-1:0] s3_ff [L];
   logic [L-1:0][W-1:0]  f4_ff;

   logic signed [SW-1:0] r_w [L];
   logic [L-1:0]         clip_w;
   logic [L-1:0][W-1:0]  f_in;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         r_w[i]    = s3_ff[i] >>> FRAC_BITS;
         clip_w[i] = !((&r_w[i][SW-1:W-1]) || !(|r_w[i][SW-1:W-1]));
         if (!ctl3_ff.hit) begin
            f_in[i] = '0;
         end else if (clip_w[i]) begin
            f_in[i] = r_w[i][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            f_in[i] = r_w[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff   <= '0;
         ctl2_ff   <= '0;
         ctl3_ff   <= '0;
         valid4_ff <= 1'b0;
      end else if (enable) begin
         ctl1_ff   <= in_ctl;
         ctl2_ff   <= ctl1_ff;
         ctl3_ff   <= ctl2_ff;
         valid4_ff <= ctl3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < L; i++) begin
            p1_ff[i] <= in_p[i];
            t1_ff[i] <= TW'($signed(in_dv[i])) - TW'($signed(in_p[i]));
            a2_ff[i] <= $signed(normal_gain) * $signed(p1_ff[i]);
            b2_ff[i] <= $signed(tangential_gain) * $signed(t1_ff[i]);
            s3_ff[i] <= SW'(a2_ff[i]) - SW'(b2_ff[i]) + HALF;
         end
         f4_ff     <= f_in;
         inter4_ff <= ctl3_ff.hit;
         sat4_ff   <= ctl3_ff.hit && (|clip_w);
      end
   end

   assign out_valid       = valid4_ff;
   assign out_force       = f4_ff;
   assign out_interacting = inter4_ff;
   assign out_saturated   = sat4_ff;

`ifndef NO_ASSERTIONS
   a_sat_at_limit : assert property (@(posedge clock) disable iff (reset)
      out_valid && out_saturated |->
         (f4_ff[0] == 32'h7FFF_FFFF) || (f4_ff[0] == 32'h8000_0000)
         || (f4_ff[1] == 32'h7FFF_FFFF) || (f4_ff[1] == 32'h8000_0000)
         || (f4_ff[2] == 32'h7FFF_FFFF) || (f4_ff[2] == 32'h8000_0000))
      else $error("saturation flagged but no component at a limit");
`endif

endmodule
`default_nettype wire
